// ----- design/bidirectional_connection_table_top_macros.svh -----
// ---------------------------------------------------------------------------
// bidirectional connection table assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef BIDIRECTIONAL_CONNECTION_TABLE_TOP_MACROS_SVH
`define BIDIRECTIONAL_CONNECTION_TABLE_TOP_MACROS_SVH

`ifndef SYNTH

// property that must hold at every sampled edge outside reset
`define BCT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BCT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define BCT_ASSERT(lbl, clk, rst, prop, msg)
`define BCT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- design/bct_pkg.sv -----
// ---------------------------------------------------------------------------
// bct_pkg
// shared types and constants of the bidirectional connection table
// ---------------------------------------------------------------------------
`default_nettype none

package bct_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int USED_W = 7;

  // operation codes
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_SET_STATE = 2'd2;

  localparam logic [1:0] CONN_STATE_NEW = 2'd0;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic [1:0]  new_state;
  } req_t;

  typedef struct packed {
    logic              found;
    logic              full_drop;
    logic [USED_W-1:0] entries_used;
  } rsp_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  conn_state;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // forward or reverse match of a stored connection
  function automatic logic entry_match(entry_t e, req_t r);
    logic fwd;
    logic rev;
    fwd = (e.src_addr == r.src_addr) && (e.dst_addr == r.dst_addr) &&
          (e.sport == r.src_port_num) && (e.dport == r.dst_port_num);
    rev = (e.src_addr == r.dst_addr) && (e.dst_addr == r.src_addr) &&
          (e.sport == r.dst_port_num) && (e.dport == r.src_port_num);
    return fwd || rev;
  endfunction

endpackage

`default_nettype wire

// ----- design/bct_ram.sv -----
// ---------------------------------------------------------------------------
// bct_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module bct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/bidirectional_connection_table_top.sv -----
// ---------------------------------------------------------------------------
// bidirectional_connection_table_top
// connection table with lookup, append and state update over one table ram
// ---------------------------------------------------------------------------
//
//  channel | signals                   | direction | payload
//  --------+---------------------------+-----------+--------------------------
//  req     | req_valid, req_stall, req | in        | func, addresses, ports,
//          |                           |           | new_state
//  rsp     | rsp_valid, rsp_stall, rsp | out       | found, full_drop,
//          |                           |           | entries_used
//
// lookup and set state: accept, one table ram read per valid entry in the scan
//   state, the drain state for the last read data, then the finish state loads
//   the result register; the ram read port sets the scan rate
// insert, unused code, or empty table: the finish state follows accept
// reset clears the entry count and control state; table contents stay
//   undefined and are never read past the count
// a result waiting under rsp_stall does not block the next req beat; a
//   second result waits in the finish state until the register frees up
// ---------------------------------------------------------------------------
`default_nettype none

`include "bidirectional_connection_table_top_macros.svh"

module bidirectional_connection_table_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire bct_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bct_pkg::rsp_t      rsp
);

  localparam int AW = bct_pkg::ADDR_W;
  localparam int CW = bct_pkg::CNT_W;
  localparam int UW = bct_pkg::USED_W;
  localparam int EW = bct_pkg::ENTRY_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(bct_pkg::TABLE_ENTRIES);

  // one-hot sequencer
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t          state;
  bct_pkg::req_t   cur;        // operation in progress
  logic [CW-1:0]   count;      // valid entries
  logic [AW-1:0]   idx;        // scan read address
  logic            rd_pend;    // read data arrives this cycle
  logic [AW-1:0]   rd_idx;     // address of that read data
  logic            hit;
  logic            drop;

  logic            accept;
  logic            last_idx;
  logic            rd_match;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  bct_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [EW-1:0]   mem_rdata;
  bct_pkg::entry_t rd_entry;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign last_idx  = (CW'(idx) == count - CW'(1));
  assign rd_entry  = bct_pkg::entry_t'(mem_rdata);
  assign rd_match  = rd_pend && bct_pkg::entry_match(rd_entry, cur);
  assign mem_re    = (state == ST_SCAN);

  // ram write side: append on insert, write back the state on a set-state hit
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = rd_entry;
    priority if (accept && req.func == bct_pkg::FUNC_INSERT && count < FULL_COUNT) begin
      mem_we               = 1'b1;
      mem_waddr            = count[AW-1:0];
      mem_wdata.src_addr   = req.src_addr;
      mem_wdata.dst_addr   = req.dst_addr;
      mem_wdata.sport      = req.src_port_num;
      mem_wdata.dport      = req.dst_port_num;
      mem_wdata.conn_state = bct_pkg::CONN_STATE_NEW;
    end else if (rd_match && cur.func == bct_pkg::FUNC_SET_STATE) begin
      mem_we               = 1'b1;
      mem_wdata.conn_state = cur.new_state;
    end else begin
      mem_we = 1'b0;
    end
  end

  bct_ram #(
    .WIDTH (EW),
    .DEPTH (bct_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (EW'(mem_wdata)),
    .re    (mem_re),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_pend <= mem_re;
      rd_idx  <= idx;

      // result register drains here unless the finish state reloads it
      if (rsp_valid && !rsp_stall && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur  <= req;
            idx  <= '0;
            hit  <= 1'b0;
            drop <= 1'b0;
            if ((req.func == bct_pkg::FUNC_LOOKUP || req.func == bct_pkg::FUNC_SET_STATE)
                && count != '0) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
            if (req.func == bct_pkg::FUNC_INSERT) begin
              if (count < FULL_COUNT) begin
                count <= count + CW'(1);
              end else begin
                drop <= 1'b1;
              end
            end
          end
        end
        ST_SCAN: begin
          if (last_idx) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid         <= 1'b1;
            rsp.found         <= hit;
            rsp.full_drop     <= drop;
            rsp.entries_used  <= UW'(count);
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (rd_match) begin
        hit <= 1'b1;
      end
    end
  end

  // checks
  `BCT_ASSERT(a_count_bound, clk, rst, count <= FULL_COUNT, "entry count above table size")
  `BCT_ASSERT_IMPL(a_read_valid, clk, rst, rd_pend, CW'(rd_idx) < count,
                   "scan read past the entry count")
  `BCT_ASSERT_IMPL(a_drop_full, clk, rst, rsp_valid && rsp.full_drop, count == FULL_COUNT,
                   "insert dropped while the table has room")
  `BCT_ASSERT_IMPL(a_count_step, clk, rst, !$past(rst) && count != $past(count),
                   count == $past(count) + CW'(1), "entry count moved by more than one")

endmodule

`default_nettype wire
